// ===== hdl/pdm_pkg.sv =====
package pdm_pkg;

    localparam int COLUMNS            = 480;
    localparam int SCREEN_ROWS        = 400;
    localparam int ROW_OFFSET         = 56;
    localparam int SAMPLE_COUNT_RESET = 480;

    localparam int SAMPLE_W    = 16;
    localparam int COLUMN_W    = $clog2(COLUMNS);
    localparam int CNT_W       = $clog2(COLUMNS + 1);
    localparam int ROW_W       = $clog2(SCREEN_ROWS + 1);
    localparam int LEN_W       = $clog2((2 ** SAMPLE_W - 1) / COLUMNS + 1);
    localparam int REM_W       = $clog2(COLUMNS);
    localparam int WSTART_W    = SAMPLE_W + 1;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = SAMPLE_W;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_COUNT = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_MODE  = CFG_INDEX_W'(1);

    typedef struct packed {
        logic [COLUMN_W-1:0] column;
        logic [SAMPLE_W-1:0] peak;
        logic [SAMPLE_W-1:0] position;
        logic                offset_mode;
    } col_req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

// ===== hdl/pdm_front.sv =====
module pdm_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [pdm_pkg::SAMPLE_W-1:0]     sample,
    input  logic                             first_of_frame,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pdm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pdm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  pdm_pkg::queue_stat_t             q_stat,
    output logic                             push,
    output pdm_pkg::col_req_t                push_req
);
    import pdm_pkg::*;

    localparam int RECIP_SHIFT = SAMPLE_W + $clog2(COLUMNS);
    localparam int RECIP       = (2 ** RECIP_SHIFT + COLUMNS - 1) / COLUMNS;
    localparam int RECIP_W     = $clog2(RECIP + 1);
    localparam int PROD_W      = SAMPLE_W + RECIP_W;
    localparam int SUM_W       = REM_W + 1;
    localparam int RESET_N     = (SAMPLE_COUNT_RESET < COLUMNS) ? COLUMNS : SAMPLE_COUNT_RESET;

    logic [SAMPLE_W-1:0] frame_n_reg;
    logic [LEN_W-1:0]    quot_reg;
    logic                pending_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [REM_W-1:0]    rem_reg;
    logic                mode_reg;

    logic [SAMPLE_W-1:0] frame_n;
    logic [PROD_W-1:0]   prod;

    logic [SAMPLE_W-1:0] idx_reg, idx_next, idx_cur;
    logic [CNT_W-1:0]    col_reg, col_next, col_cur;
    logic [WSTART_W-1:0] wstart_reg, wstart_next, wstart_cur, wstart_adv;
    logic [REM_W-1:0]    racc_reg, racc_next, racc_cur, racc_adv;
    logic [LEN_W-1:0]    fill_reg, fill_next, fill_cur, fill_inc;
    logic [SAMPLE_W-1:0] peak_reg, peak_next, peak_cur, peak_new;
    logic [SAMPLE_W-1:0] pos_reg, pos_next, pos_cur, pos_new;

    logic [SUM_W-1:0] sum_rem;
    logic [SUM_W-1:0] rem_sub;
    logic             carry;
    logic             take;
    logic             upd;
    logic             close;
    logic             accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_stat.full || pending_reg;
    assign accept    = in_valid && !in_stall;

    assign frame_n = (cfg_data < CFG_DATA_W'(COLUMNS)) ? SAMPLE_W'(COLUMNS) : cfg_data;
    assign prod    = PROD_W'(frame_n) * PROD_W'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_n_reg <= SAMPLE_W'(RESET_N);
            quot_reg    <= LEN_W'(RESET_N / COLUMNS);
            pending_reg <= 1'b0;
            len_reg     <= LEN_W'(RESET_N / COLUMNS);
            rem_reg     <= REM_W'(RESET_N % COLUMNS);
            mode_reg    <= 1'b0;
        end
        else
        begin
            pending_reg <= 1'b0;
            if (pending_reg)
            begin
                len_reg <= quot_reg;
                rem_reg <= REM_W'(frame_n_reg - SAMPLE_W'(quot_reg * COLUMNS));
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SAMPLE_COUNT:
                    begin
                        frame_n_reg <= frame_n;
                        quot_reg    <= prod[RECIP_SHIFT +: LEN_W];
                        pending_reg <= 1'b1;
                    end
                    CFG_OFFSET_MODE:
                    begin
                        mode_reg <= cfg_data[0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        idx_cur    = first_of_frame ? '0 : idx_reg;
        col_cur    = first_of_frame ? '0 : col_reg;
        wstart_cur = first_of_frame ? '0 : wstart_reg;
        racc_cur   = first_of_frame ? '0 : racc_reg;
        fill_cur   = first_of_frame ? '0 : fill_reg;
        peak_cur   = first_of_frame ? '0 : peak_reg;
        pos_cur    = first_of_frame ? '0 : pos_reg;

        take     = (col_cur < CNT_W'(COLUMNS)) && (WSTART_W'(idx_cur) >= wstart_cur);
        upd      = (fill_cur == '0) || (sample > peak_cur);
        peak_new = upd ? sample : peak_cur;
        pos_new  = upd ? idx_cur : pos_cur;
        fill_inc = fill_cur + 1'b1;
        close    = take && (fill_inc >= len_reg);

        sum_rem    = SUM_W'(racc_cur) + SUM_W'(rem_reg);
        carry      = sum_rem >= SUM_W'(COLUMNS);
        rem_sub    = sum_rem - SUM_W'(COLUMNS);
        racc_adv   = carry ? rem_sub[REM_W-1:0] : sum_rem[REM_W-1:0];
        wstart_adv = wstart_cur + WSTART_W'(len_reg) + WSTART_W'(carry);

        idx_next    = idx_reg;
        col_next    = col_reg;
        wstart_next = wstart_reg;
        racc_next   = racc_reg;
        fill_next   = fill_reg;
        peak_next   = peak_reg;
        pos_next    = pos_reg;

        if (accept)
        begin
            idx_next    = (idx_cur == '1) ? idx_cur : idx_cur + 1'b1;
            col_next    = col_cur;
            wstart_next = wstart_cur;
            racc_next   = racc_cur;
            fill_next   = fill_cur;
            peak_next   = peak_cur;
            pos_next    = pos_cur;
            if (take)
            begin
                peak_next = peak_new;
                pos_next  = pos_new;
                fill_next = fill_inc;
                if (close)
                begin
                    col_next    = col_cur + 1'b1;
                    wstart_next = wstart_adv;
                    racc_next   = racc_adv;
                    fill_next   = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            col_reg    <= '0;
            wstart_reg <= '0;
            racc_reg   <= '0;
            fill_reg   <= '0;
            peak_reg   <= '0;
            pos_reg    <= '0;
        end
        else
        begin
            idx_reg    <= idx_next;
            col_reg    <= col_next;
            wstart_reg <= wstart_next;
            racc_reg   <= racc_next;
            fill_reg   <= fill_next;
            peak_reg   <= peak_next;
            pos_reg    <= pos_next;
        end
    end

    assign push                 = accept && close;
    assign push_req.column      = col_cur[COLUMN_W-1:0];
    assign push_req.peak        = peak_new;
    assign push_req.position    = pos_new;
    assign push_req.offset_mode = mode_reg;

endmodule

// ===== hdl/pdm_queue.sv =====
module pdm_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pdm_pkg::col_req_t    push_req,
    input  logic                 pop,
    output pdm_pkg::col_req_t    pop_req,
    output pdm_pkg::queue_stat_t q_stat
);
    import pdm_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    col_req_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

    assign pop_req      = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule

// ===== hdl/pdm_back.sv =====
module pdm_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pdm_pkg::queue_stat_t          q_stat,
    output logic                          pop,
    input  pdm_pkg::col_req_t             pop_req,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pdm_pkg::COLUMN_W-1:0]  column,
    output logic [pdm_pkg::SAMPLE_W-1:0]  peak_value,
    output logic [pdm_pkg::SAMPLE_W-1:0]  peak_position,
    output logic [pdm_pkg::ROW_W-1:0]     display_row
);
    import pdm_pkg::*;

    logic                 out_valid_reg;
    logic [COLUMN_W-1:0]  column_reg;
    logic [SAMPLE_W-1:0]  peak_reg;
    logic [SAMPLE_W-1:0]  position_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [ROW_W-1:0]     row_next;
    logic [SAMPLE_W-1:0]  peak_in;
    logic                 load;

    assign peak_in = pop_req.peak;

    always_comb
    begin
        if (pop_req.offset_mode)
        begin
            if (peak_in < SAMPLE_W'(ROW_OFFSET))
            begin
                row_next = ROW_W'(SCREEN_ROWS);
            end
            else if (peak_in >= SAMPLE_W'(SCREEN_ROWS + ROW_OFFSET))
            begin
                row_next = '0;
            end
            else
            begin
                row_next = ROW_W'(SAMPLE_W'(SCREEN_ROWS + ROW_OFFSET) - peak_in);
            end
        end
        else
        begin
            if (peak_in >= SAMPLE_W'(SCREEN_ROWS))
            begin
                row_next = '0;
            end
            else
            begin
                row_next = ROW_W'(SAMPLE_W'(SCREEN_ROWS) - peak_in);
            end
        end
    end

    assign load = !out_valid_reg || !out_stall;
    assign pop  = load && !q_stat.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= !q_stat.empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            column_reg   <= pop_req.column;
            peak_reg     <= pop_req.peak;
            position_reg <= pop_req.position;
            row_reg      <= row_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign column        = column_reg;
    assign peak_value    = peak_reg;
    assign peak_position = position_reg;
    assign display_row   = row_reg;

endmodule

// ===== hdl/peak_decimator_display_map_unit.sv =====
// Peak-detecting decimator: reduces a frame of samples to 480 display columns,
// one result per closed column window (column, peak, first peak position, screen
// row). One sample is taken per clock while in_stall is low; a result reaches out_valid
// from the sample that closes its window through a two-entry queue and an output
// register, so in_stall rises on a full queue, seen only under output backpressure.
// A write to sample_count holds in_stall high for one cycle while the window length
// and remainder are derived by a constant reciprocal multiply; cfg_ready is always high.
module peak_decimator_display_map_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [pdm_pkg::SAMPLE_W-1:0]     sample,
    input  logic                             first_of_frame,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [pdm_pkg::COLUMN_W-1:0]     column,
    output logic [pdm_pkg::SAMPLE_W-1:0]     peak_value,
    output logic [pdm_pkg::SAMPLE_W-1:0]     peak_position,
    output logic [pdm_pkg::ROW_W-1:0]        display_row,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pdm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pdm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pdm_pkg::*;

    queue_stat_t q_stat;
    col_req_t    push_req;
    col_req_t    pop_req;
    logic        push;
    logic        pop;

    pdm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample         (sample),
        .first_of_frame (first_of_frame),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .q_stat         (q_stat),
        .push           (push),
        .push_req       (push_req)
    );

    pdm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .pop_req  (pop_req),
        .q_stat   (q_stat)
    );

    pdm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .pop           (pop),
        .pop_req       (pop_req),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .column        (column),
        .peak_value    (peak_value),
        .peak_position (peak_position),
        .display_row   (display_row)
    );

endmodule

// ===== hdl/pdm_checker.sv =====
module pdm_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [pdm_pkg::COLUMN_W-1:0]     column,
    input  logic [pdm_pkg::SAMPLE_W-1:0]     peak_value,
    input  logic [pdm_pkg::SAMPLE_W-1:0]     peak_position,
    input  logic [pdm_pkg::ROW_W-1:0]        display_row
);
    import pdm_pkg::*;

    logic                seen_reg;
    logic [COLUMN_W-1:0] last_col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= 1'b0;
            last_col_reg <= '0;
        end
        else if (out_valid && !out_stall)
        begin
            seen_reg     <= 1'b1;
            last_col_reg <= column;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(column) && $stable(peak_value)
            && $stable(peak_position) && $stable(display_row))
        else $error("result changed while stalled");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> column < COLUMN_W'(COLUMNS))
        else $error("column out of range");

    a_col_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seen_reg |-> column == COLUMN_W'(last_col_reg + 1'b1) || column == '0)
        else $error("column out of order");

    a_row_map: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> display_row <= ROW_W'(SCREEN_ROWS)
            && (peak_value < SAMPLE_W'(SCREEN_ROWS + ROW_OFFSET) || display_row == '0))
        else $error("display row inconsistent with peak");

endmodule

bind peak_decimator_display_map_unit pdm_checker u_pdm_checker (.*);

// ===== dv/peak_decimator_display_map_unit_tb.sv =====
`timescale 1ns / 100ps

module peak_decimator_display_map_unit_tb;
    import pdm_pkg::*;

    localparam int CLK_PERIOD        = 10;
    localparam int RESET_CYCLES      = 6;
    localparam int SETTLE_CYCLES     = 8;
    localparam int LONG_HOLD_CYCLES  = 60;
    localparam int RANDOM_ITEMS      = 1500;
    localparam int FINAL_FRAME_ITEMS = 250;
    localparam int TIMEOUT_CYCLES    = 500_000;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = CFG_INDEX_W'(3);

    typedef struct packed {
        logic [COLUMN_W-1:0] column;
        logic [SAMPLE_W-1:0] peak;
        logic [SAMPLE_W-1:0] position;
        logic [ROW_W-1:0]    row;
    } column_result_t;

    typedef enum logic {STEP_SAMPLE, STEP_WRITE} step_kind_t;

    typedef enum logic [1:0] {FRAME_CLEAN, FRAME_CONTINUE, FRAME_NOISE} frame_kind_t;

    typedef struct {
        step_kind_t             kind;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  value;
        logic                   first;
        bit                     checked;
        column_result_t         result;
    } directed_step_t;

    logic                   clk            = 1'b0;
    logic                   rst_n          = 1'b0;
    logic                   in_valid       = 1'b0;
    logic                   in_stall;
    logic [SAMPLE_W-1:0]    sample         = '0;
    logic                   first_of_frame = 1'b0;
    logic                   out_valid;
    logic                   out_stall      = 1'b0;
    logic [COLUMN_W-1:0]    column;
    logic [SAMPLE_W-1:0]    peak_value;
    logic [SAMPLE_W-1:0]    peak_position;
    logic [ROW_W-1:0]       display_row;
    logic                   cfg_valid      = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index      = '0;
    logic [CFG_DATA_W-1:0]  cfg_data       = '0;

    logic [CFG_DATA_W-1:0]  frame_samples  = CFG_DATA_W'(SAMPLE_COUNT_RESET);
    logic                   offset_on      = 1'b0;
    int unsigned            next_index     = 0;
    int unsigned            open_column    = 0;
    int unsigned            window_base    = 0;
    int unsigned            base_remainder = 0;
    int unsigned            window_taken   = 0;
    int unsigned            best_value     = 0;
    int unsigned            best_index     = 0;

    column_result_t         expected_columns[$];
    directed_step_t         directed_steps[$];
    logic [SAMPLE_W-1:0]    last_value     = '0;
    int                     failures       = 0;
    int unsigned            items_sent     = 0;
    bit                     tx_idling      = 1'b1;
    bit                     rx_idling      = 1'b1;
    int unsigned            hold_requests  = 0;
    int unsigned            holds_served   = 0;
    int unsigned            hold_left      = 0;

    peak_decimator_display_map_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample         (sample),
        .first_of_frame (first_of_frame),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .column         (column),
        .peak_value     (peak_value),
        .peak_position  (peak_position),
        .display_row    (display_row),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    function automatic logic [ROW_W-1:0] peak_to_row(input int unsigned pk);
        int unsigned height;
        if (offset_on)
        begin
            if (pk < ROW_OFFSET)
                height = 0;
            else if (pk - ROW_OFFSET > SCREEN_ROWS)
                height = SCREEN_ROWS;
            else
                height = pk - ROW_OFFSET;
        end
        else
            height = (pk > SCREEN_ROWS) ? SCREEN_ROWS : pk;
        return ROW_W'(SCREEN_ROWS - height);
    endfunction

    function automatic bit decimate_sample(input logic [SAMPLE_W-1:0] value, input logic first,
                                           output column_result_t res);
        int unsigned n_eff;
        int unsigned win_len;
        int unsigned win_rem;
        n_eff   = (frame_samples < COLUMNS) ? COLUMNS : frame_samples;
        win_len = n_eff / COLUMNS;
        win_rem = n_eff % COLUMNS;
        if (win_len == 0)
            win_len = 1;
        res = '0;
        decimate_sample = 1'b0;
        if (first)
        begin
            next_index     = 0;
            open_column    = 0;
            window_base    = 0;
            base_remainder = 0;
            window_taken   = 0;
            best_value     = 0;
            best_index     = 0;
        end
        if (open_column < COLUMNS && next_index >= window_base)
        begin
            if (window_taken == 0 || value > best_value)
            begin
                best_value = value;
                best_index = next_index;
            end
            window_taken++;
            if (window_taken >= win_len)
            begin
                res.column      = COLUMN_W'(open_column);
                res.peak        = SAMPLE_W'(best_value);
                res.position    = SAMPLE_W'(best_index);
                res.row         = peak_to_row(best_value);
                decimate_sample = 1'b1;
                open_column++;
                window_base    += win_len;
                base_remainder += win_rem;
                if (base_remainder >= COLUMNS)
                begin
                    base_remainder -= COLUMNS;
                    window_base++;
                end
                window_taken = 0;
            end
        end
        if (next_index < 32'hFFFF)
            next_index++;
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 3))
            0: last_value = SAMPLE_W'($urandom);
            1: last_value = SAMPLE_W'($urandom_range(0, 520));
            2: ;  // hold the previous value to force ties
            default: last_value = $urandom_range(0, 1) ? '1 : '0;
        endcase
        return last_value;
    endfunction

    function automatic directed_step_t sample_step(input logic [SAMPLE_W-1:0] value,
                                                   input logic first);
        directed_step_t s;
        s.kind    = STEP_SAMPLE;
        s.index   = '0;
        s.value   = value;
        s.first   = first;
        s.checked = 1'b0;
        s.result  = '0;
        return s;
    endfunction

    function automatic directed_step_t checked_step(input logic [SAMPLE_W-1:0] value,
                                                    input logic first, input int col,
                                                    input int pk, input int pos, input int rw);
        directed_step_t s;
        s                 = sample_step(value, first);
        s.checked         = 1'b1;
        s.result.column   = COLUMN_W'(col);
        s.result.peak     = SAMPLE_W'(pk);
        s.result.position = SAMPLE_W'(pos);
        s.result.row      = ROW_W'(rw);
        return s;
    endfunction

    function automatic directed_step_t write_step(input logic [CFG_INDEX_W-1:0] index,
                                                  input logic [CFG_DATA_W-1:0] value);
        directed_step_t s;
        s.kind    = STEP_WRITE;
        s.index   = index;
        s.value   = value;
        s.first   = 1'b0;
        s.checked = 1'b0;
        s.result  = '0;
        return s;
    endfunction

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_columns.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            CFG_SAMPLE_COUNT: frame_samples = value;
            CFG_OFFSET_MODE:  offset_on = value[0];
            default: ;
        endcase
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic first,
                               input bit checked, input column_result_t typed);
        column_result_t predicted;
        bit             has_result;
        if (tx_idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        sample         <= value;
        first_of_frame <= first;
        do
            @(posedge clk);
        while (in_stall);
        has_result = decimate_sample(value, first, predicted);
        if (checked)
            expected_columns.push_back(typed);
        else if (has_result)
            expected_columns.push_back(predicted);
        items_sent++;
    endtask

    task automatic send_frame(input frame_kind_t kind, input int unsigned length);
        logic first;
        for (int unsigned i = 0; i < length; i++)
        begin
            case (kind)
                FRAME_CLEAN:    first = (i == 0);
                FRAME_CONTINUE: first = 1'b0;
                default:        first = ($urandom_range(0, 7) == 0);
            endcase
            send_sample(random_sample(), first, 1'b0, '0);
        end
    endtask

    // long hold-off on request, otherwise short random bursts
    always @(posedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (rx_idling && $urandom_range(0, 5) == 0)
        begin
            hold_left = $urandom_range(0, 4);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : check_results
        column_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_columns.size() == 0)
            begin
                $error("unexpected result: column %0d peak %0d", column, peak_value);
                failures++;
            end
            else
            begin
                want = expected_columns.pop_front();
                if (column !== want.column)
                begin
                    $error("column: expected %0d, got %0d", want.column, column);
                    failures++;
                end
                if (peak_value !== want.peak)
                begin
                    $error("peak_value: expected %0d, got %0d", want.peak, peak_value);
                    failures++;
                end
                if (peak_position !== want.position)
                begin
                    $error("peak_position: expected %0d, got %0d", want.position, peak_position);
                    failures++;
                end
                if (display_row !== want.row)
                begin
                    $error("display_row: expected %0d, got %0d", want.row, display_row);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("peak_decimator_display_map_unit regression: fail");
        $finish;
    end

    initial
    begin
        directed_step_t step;
        int unsigned    random_base;
        int unsigned    phase;
        int unsigned    n_eff;
        int unsigned    frame_len;
        int unsigned    remaining;
        frame_kind_t    frame_kind;
        logic [CFG_DATA_W-1:0] count_cfg;
        logic [CFG_DATA_W-1:0] mode_cfg;

        // plain mapping, one sample per column after reset
        directed_steps.push_back(checked_step(16'd0,     1'b0, 0, 0,      0, 400));
        directed_steps.push_back(checked_step(16'hFFFF,  1'b0, 1, 65535,  1, 0));
        directed_steps.push_back(checked_step(16'd400,   1'b0, 2, 400,    2, 0));
        directed_steps.push_back(checked_step(16'd399,   1'b0, 3, 399,    3, 1));
        directed_steps.push_back(checked_step(16'hAAAA,  1'b1, 0, 16'hAAAA, 0, 0));
        // offset mapping and its clamps
        directed_steps.push_back(write_step(CFG_OFFSET_MODE, 16'd1));
        directed_steps.push_back(checked_step(16'd55,    1'b1, 0, 55,     0, 400));
        directed_steps.push_back(checked_step(16'd56,    1'b0, 1, 56,     1, 400));
        directed_steps.push_back(checked_step(16'd456,   1'b0, 2, 456,    2, 0));
        directed_steps.push_back(checked_step(16'd457,   1'b0, 3, 457,    3, 0));
        directed_steps.push_back(checked_step(16'h5555,  1'b0, 4, 16'h5555, 4, 0));
        directed_steps.push_back(checked_step(16'd300,   1'b0, 5, 300,    5, 156));
        // three-sample windows, tie keeps the earlier sample
        directed_steps.push_back(write_step(CFG_SAMPLE_COUNT, 16'd1440));
        directed_steps.push_back(sample_step(16'd7,      1'b1));
        directed_steps.push_back(sample_step(16'd9,      1'b0));
        directed_steps.push_back(checked_step(16'd9,     1'b0, 0, 9,      1, 400));
        // short frame saturates to one sample per column
        directed_steps.push_back(write_step(CFG_SAMPLE_COUNT, 16'd0));
        directed_steps.push_back(checked_step(16'd1234,  1'b1, 0, 1234,   0, 0));
        directed_steps.push_back(write_step(CFG_SPARE_2, 16'hFFFF));
        directed_steps.push_back(write_step(CFG_SPARE_3, 16'hFFFF));
        directed_steps.push_back(checked_step(16'd100,   1'b0, 1, 100,    1, 356));
        // registers changed mid-frame
        directed_steps.push_back(write_step(CFG_OFFSET_MODE, 16'd0));
        directed_steps.push_back(write_step(CFG_SAMPLE_COUNT, 16'd961));
        directed_steps.push_back(sample_step(16'd3,      1'b0));
        directed_steps.push_back(sample_step(16'd8,      1'b0));
        directed_steps.push_back(sample_step(16'hFFFF,   1'b0));
        directed_steps.push_back(sample_step(16'd2,      1'b0));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i])
        begin
            step = directed_steps[i];
            if (step.kind == STEP_WRITE)
                write_register(step.index, step.value);
            else
                send_sample(SAMPLE_W'(step.value), step.first, step.checked, step.result);
        end

        phase       = 0;
        random_base = items_sent;
        while (items_sent - random_base < RANDOM_ITEMS)
        begin
            if (phase == 0)
                count_cfg = CFG_DATA_W'(COLUMNS);
            else
                case ($urandom_range(0, 7))
                    0:       count_cfg = CFG_DATA_W'($urandom_range(0, COLUMNS - 1));
                    1, 2:    count_cfg = CFG_DATA_W'(COLUMNS);
                    3:       count_cfg = CFG_DATA_W'($urandom_range(COLUMNS + 1, 600));
                    4:       count_cfg = CFG_DATA_W'($urandom_range(900, 1000));
                    5:       count_cfg = CFG_DATA_W'($urandom_range(1400, 1500));
                    default: count_cfg = CFG_DATA_W'($urandom);
                endcase
            mode_cfg = CFG_DATA_W'($urandom_range(0, 1));
            if ($urandom_range(0, 1))
            begin
                write_register(CFG_SAMPLE_COUNT, count_cfg);
                write_register(CFG_OFFSET_MODE, mode_cfg);
            end
            else
            begin
                write_register(CFG_OFFSET_MODE, mode_cfg);
                write_register(CFG_SAMPLE_COUNT, count_cfg);
            end
            tx_idling = ($urandom_range(0, 3) != 0);
            rx_idling <= ($urandom_range(0, 3) != 0);
            n_eff     = (count_cfg < COLUMNS) ? COLUMNS : count_cfg;
            remaining = RANDOM_ITEMS - (items_sent - random_base);
            if (phase == 0)
            begin
                // hold the output while requests keep coming
                hold_requests <= hold_requests + 1;
                frame_kind = FRAME_CLEAN;
                frame_len  = COLUMNS + 4;
            end
            else
                case ($urandom_range(0, 9))
                    0, 1, 2:
                    begin
                        frame_kind = FRAME_CLEAN;
                        frame_len  = (n_eff <= 1500) ? n_eff + $urandom_range(0, 8) :
                                                       $urandom_range(100, 300);
                    end
                    3, 4, 5, 6:
                    begin
                        frame_kind = FRAME_CLEAN;
                        frame_len  = $urandom_range(20, 200);
                    end
                    7:
                    begin
                        frame_kind = FRAME_CONTINUE;
                        frame_len  = $urandom_range(20, 200);
                    end
                    default:
                    begin
                        frame_kind = FRAME_NOISE;
                        frame_len  = $urandom_range(10, 40);
                    end
                endcase
            send_frame(frame_kind, (frame_len < remaining) ? frame_len : remaining);
            phase++;
        end

        // full-rate frame, one sample per column, no idling
        write_register(CFG_SAMPLE_COUNT, CFG_DATA_W'(COLUMNS));
        write_register(CFG_OFFSET_MODE, CFG_DATA_W'($urandom_range(0, 1)));
        tx_idling = 1'b0;
        rx_idling <= 1'b0;
        send_frame(FRAME_CLEAN, FINAL_FRAME_ITEMS);

        wait_idle();
        if (failures == 0)
            $display("peak_decimator_display_map_unit regression: pass");
        else
            $display("peak_decimator_display_map_unit regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/pdm_pkg.sv
hdl/pdm_front.sv
hdl/pdm_queue.sv
hdl/pdm_back.sv
hdl/peak_decimator_display_map_unit.sv
hdl/pdm_checker.sv
dv/peak_decimator_display_map_unit_tb.sv
